/* rtl/core/tab_pkg.sv */
// ----------------------------------------------------------------------------
// tab_pkg
// Types and constants shared by the tilt angle binning block: payload structs,
// controller states, the controller-to-datapath command and the CORDIC table.
// ----------------------------------------------------------------------------
package tab_pkg;

  // Angle accumulator fraction bits and number of table entries.
  localparam int ZACC_FRAC = 20;
  localparam int TABLE_LEN = 24;
  localparam int STEP_W    = 5;

  // Raw axis value minus offset spans -255..255.
  localparam int AXIS_W    = 9;
  // Vector components carry 16 fraction bits and grow by the CORDIC gain.
  localparam int VEC_FRAC  = 16;
  localparam int XW        = 28;
  localparam int ZW        = 29;
  localparam int TAB_W     = 27;

  localparam int RAW_W     = 8;
  localparam int ANGLE_W   = 16;
  localparam int CODE_W    = 4;
  localparam int NUM_BINS  = 10;
  localparam int BIN_DEG   = 10;
  localparam int RIGHT_DEG = 90;

  localparam logic [RAW_W-1:0] ADC_OFFSET_RST = 8'd81;

  // atan(2^-i) in degrees, units of 2^-20 degree.
  localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  typedef struct packed {
    logic [RAW_W-1:0] accel_x_raw;
    logic [RAW_W-1:0] accel_y_raw;
    logic [RAW_W-1:0] accel_z_raw;
  } tab_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_xy;
    logic signed [ANGLE_W-1:0] angle_xz;
    logic signed [ANGLE_W-1:0] angle_yz;
    logic [CODE_W-1:0]         display_code;
  } tab_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_ROUND,
    ST_FIN
  } tab_state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              round;
    logic              finish;
    logic [STEP_W-1:0] step_idx;
  } tab_cmd_t;

endpackage

/* rtl/core/tab_ctrl.sv */
// ----------------------------------------------------------------------------
// tab_ctrl
// Sequencer: takes a sample, runs the CORDIC iterations, rounds, and hands the
// result to the output register when it is free.
// ----------------------------------------------------------------------------
module tab_ctrl
  import tab_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tab_cmd_t cmd
);

  localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

  tab_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_ITER;
      ST_ITER:  if (cnt_r == LAST_STEP) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.step_idx  = cnt_r;
    in_ready      = 1'b0;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cnt_nxt  = '0;
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/tab_dp.sv */
// ----------------------------------------------------------------------------
// tab_dp
// Datapath: offset register, three vectoring CORDIC lanes that iterate side by
// side, rounding and clamping, display binning and the output register.
// ----------------------------------------------------------------------------
module tab_dp
  import tab_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [RAW_W-1:0] cfg_wr_data,
  input  tab_in_t          in_data,
  input  tab_cmd_t         cmd,
  output tab_out_t         out_data
);

  localparam int LIM   = RIGHT_DEG * (1 << ANGLE_FRAC_BITS);
  localparam int TEN   = BIN_DEG * (1 << ANGLE_FRAC_BITS);
  localparam int ANG_W = $clog2(LIM + 1) + 1;
  localparam int SH    = ZACC_FRAC - ANGLE_FRAC_BITS;
  localparam int HALF  = 1 << (SH - 1);

  logic [RAW_W-1:0]         offset_r;
  logic signed [XW-1:0]     x_r [3];
  logic signed [XW-1:0]     y_r [3];
  logic signed [ZW-1:0]     z_r [3];
  logic                     spec_r [3];
  logic signed [ANG_W-1:0]  spec_val_r [3];
  logic signed [ANG_W-1:0]  ang_r [3];
  logic [CODE_W-1:0]        hold_r;
  tab_out_t                 out_r;

  logic signed [AXIS_W-1:0] axis [3];
  logic signed [AXIS_W-1:0] num [3];
  logic signed [AXIS_W-1:0] den [3];
  logic signed [AXIS_W-1:0] num_n [3];
  logic signed [AXIS_W-1:0] den_n [3];
  logic signed [XW-1:0]     x0 [3];
  logic signed [XW-1:0]     y0 [3];
  logic                     spec [3];
  logic signed [ANG_W-1:0]  spec_val [3];
  logic signed [XW-1:0]     x_step [3];
  logic signed [XW-1:0]     y_step [3];
  logic signed [ZW-1:0]     z_step [3];
  logic signed [ZW-1:0]     z_rnd [3];
  logic signed [ANG_W-1:0]  ang_nxt [3];
  logic signed [ZW-1:0]     tab_val;
  logic [CODE_W-1:0]        code;

  always_comb begin
    axis[0] = signed'({1'b0, in_data.accel_x_raw}) - signed'({1'b0, offset_r});
    axis[1] = signed'({1'b0, in_data.accel_y_raw}) - signed'({1'b0, offset_r});
    axis[2] = signed'({1'b0, in_data.accel_z_raw}) - signed'({1'b0, offset_r});
    // Lanes: xy = atan(x/y), xz = atan(z/x), yz = atan(y/z).
    num[0] = axis[0];  den[0] = axis[1];
    num[1] = axis[2];  den[1] = axis[0];
    num[2] = axis[1];  den[2] = axis[2];
  end

  assign tab_val = ZW'(ATAN_TAB[cmd.step_idx]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      spec[l]     = (den[l] == '0) || (num[l] == '0);
      spec_val[l] = '0;
      if (den[l] == '0) begin
        if (num[l] > 0) spec_val[l] = ANG_W'(LIM);
        else if (num[l] < 0) spec_val[l] = -ANG_W'(LIM);
      end
      // Fold the vector into the right half plane.
      if (den[l] < 0) begin
        num_n[l] = -num[l];
        den_n[l] = -den[l];
      end else begin
        num_n[l] = num[l];
        den_n[l] = den[l];
      end
      x0[l] = XW'(den_n[l]) <<< VEC_FRAC;
      y0[l] = XW'(num_n[l]) <<< VEC_FRAC;

      if (!y_r[l][XW-1]) begin
        x_step[l] = x_r[l] + (y_r[l] >>> cmd.step_idx);
        y_step[l] = y_r[l] - (x_r[l] >>> cmd.step_idx);
        z_step[l] = z_r[l] + tab_val;
      end else begin
        x_step[l] = x_r[l] - (y_r[l] >>> cmd.step_idx);
        y_step[l] = y_r[l] + (x_r[l] >>> cmd.step_idx);
        z_step[l] = z_r[l] - tab_val;
      end

      z_rnd[l] = (z_r[l] + ZW'(HALF)) >>> SH;
      if (spec_r[l]) ang_nxt[l] = spec_val_r[l];
      else if (z_rnd[l] > ZW'(LIM)) ang_nxt[l] = ANG_W'(LIM);
      else if (z_rnd[l] < -ZW'(LIM)) ang_nxt[l] = -ANG_W'(LIM);
      else ang_nxt[l] = ANG_W'(z_rnd[l]);
    end
  end

  // Highest bin whose lower edge the xz angle exceeds; none keeps the old code.
  always_comb begin
    code = hold_r;
    for (int k = 0; k < NUM_BINS; k++) begin
      if (ang_r[1] > signed'(ANG_W'(k * TEN))) code = CODE_W'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= ADC_OFFSET_RST;
      hold_r   <= '0;
    end else begin
      if (cfg_wr_en) offset_r <= cfg_wr_data;
      if (cmd.finish) hold_r <= code;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (cmd.load) begin
        x_r[l]        <= x0[l];
        y_r[l]        <= y0[l];
        z_r[l]        <= '0;
        spec_r[l]     <= spec[l];
        spec_val_r[l] <= spec_val[l];
      end else if (cmd.step) begin
        x_r[l] <= x_step[l];
        y_r[l] <= y_step[l];
        z_r[l] <= z_step[l];
      end
      if (cmd.round) ang_r[l] <= ang_nxt[l];
    end
    if (cmd.finish) begin
      out_r.angle_xy     <= ANGLE_W'(ang_r[0]);
      out_r.angle_xz     <= ANGLE_W'(ang_r[1]);
      out_r.angle_yz     <= ANGLE_W'(ang_r[2]);
      out_r.display_code <= code;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/core/tilt_angle_binning.sv */
// One sample is in work at a time: the block takes no new sample until the
// iterative CORDIC loop, the rounding and the hand-off of the last one are
// done. The three angles run in parallel lanes.
// A new sample is taken while the previous result waits in the output register.
// Reset (synchronous, rst_n low) clears control, the display code and sets the offset to 81.
// ----------------------------------------------------------------------------
// tilt_angle_binning
// Three-axis accelerometer tilt: offset removal, three plane angles by CORDIC
// and a 10-degree bin display code of the xz angle.
// ----------------------------------------------------------------------------
module tilt_angle_binning
  import tab_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [RAW_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  tab_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tab_out_t         out_data
);

  tab_cmd_t cmd;

  tab_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  tab_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_data    (in_data),
    .cmd        (cmd),
    .out_data   (out_data)
  );

endmodule

/* test/tab_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_checker
// Watches the sample, result and offset ports of the tilt angle block. It
// computes the three CORDIC plane angles and the display bin for every sample
// transfer, then compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tab_checker
  import tab_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [RAW_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  tab_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  tab_out_t         out_data,
  output int               mismatch_count,
  output int               tilt_pending
);

  // atan(2^-i) in units of 2^-20 degree.
  localparam longint DEG_ATAN_STEP [TABLE_LEN] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682,   117342,   58671,    29335,   14668,   7334,    3667,   1833,
    917,      458,      229,      115,     57,      29,      14,     7
  };

  logic [RAW_W-1:0]  zero_g_offset = ADC_OFFSET_RST;
  logic [CODE_W-1:0] display_hold  = '0;
  tab_out_t          tilt_expected_q [$];
  int                err_total     = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    err_total++;
  endtask

  function automatic longint atan_deg_fixed(input int num, input int den);
    longint vx, vy, dx, dy, acc, lim;
    int     n, d, steps, sh;
    lim = longint'(RIGHT_DEG) <<< ANGLE_FRAC_BITS;
    sh  = ZACC_FRAC - ANGLE_FRAC_BITS;
    acc = 0;
    n   = num;
    d   = den;
    if (d == 0) begin
      return (n > 0) ? lim : ((n < 0) ? -lim : 64'sd0);
    end
    if (n == 0) begin
      return 0;
    end
    // Fold the left half plane onto the right one.
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    vx    = longint'(d) * 65536;
    vy    = longint'(n) * 65536;
    steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        acc = acc + DEG_ATAN_STEP[i];
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        acc = acc - DEG_ATAN_STEP[i];
      end
    end
    acc = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    return acc;
  endfunction

  function automatic tab_out_t predict_tilt(input tab_in_t s);
    tab_out_t r;
    int       ax, ay, az;
    longint   a_xy, a_xz, a_yz, bin_w;
    ax    = int'(s.accel_x_raw) - int'(zero_g_offset);
    ay    = int'(s.accel_y_raw) - int'(zero_g_offset);
    az    = int'(s.accel_z_raw) - int'(zero_g_offset);
    a_xy  = atan_deg_fixed(ax, ay);
    a_xz  = atan_deg_fixed(az, ax);
    a_yz  = atan_deg_fixed(ay, az);
    bin_w = longint'(BIN_DEG) <<< ANGLE_FRAC_BITS;
    // The bin register only moves when the xz angle is strictly positive.
    for (int k = NUM_BINS - 1; k >= 0; k--) begin
      if (a_xz > k * bin_w) begin
        display_hold = CODE_W'(k + 1);
        break;
      end
    end
    r.angle_xy     = a_xy[ANGLE_W-1:0];
    r.angle_xz     = a_xz[ANGLE_W-1:0];
    r.angle_yz     = a_yz[ANGLE_W-1:0];
    r.display_code = display_hold;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tab_out_t want;
    if (!rst_n) begin
      zero_g_offset = ADC_OFFSET_RST;
      display_hold  = '0;
      tilt_expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        zero_g_offset = cfg_wr_data;
      end
      // A result leaving in this cycle always belongs to an earlier sample.
      if (out_valid && out_ready) begin
        if (tilt_expected_q.size() == 0) begin
          report_mismatch("result transfer with no sample outstanding");
        end else begin
          want = tilt_expected_q.pop_front();
          if (out_data.angle_xy !== want.angle_xy) begin
            report_mismatch($sformatf("angle_xy got %0d expected %0d",
                                      out_data.angle_xy, want.angle_xy));
          end
          if (out_data.angle_xz !== want.angle_xz) begin
            report_mismatch($sformatf("angle_xz got %0d expected %0d",
                                      out_data.angle_xz, want.angle_xz));
          end
          if (out_data.angle_yz !== want.angle_yz) begin
            report_mismatch($sformatf("angle_yz got %0d expected %0d",
                                      out_data.angle_yz, want.angle_yz));
          end
          if (out_data.display_code !== want.display_code) begin
            report_mismatch($sformatf("display_code got %0d expected %0d",
                                      out_data.display_code, want.display_code));
          end
        end
      end
      if (in_valid && in_ready) begin
        tilt_expected_q.push_back(predict_tilt(in_data));
      end
    end
    mismatch_count <= err_total;
    tilt_pending   <= tilt_expected_q.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives accelerometer samples and offset settings into the tilt angle block,
// with random gaps on both channels and one long result hold-off, and reports
// the verdict from the checker's mismatch and pending-result counts.
// ----------------------------------------------------------------------------
module tb_top;
  import tab_pkg::*;

  localparam int FRAC_BITS    = 8;
  localparam int STEPS        = 16;
  localparam int SEG_SAMPLES  = 175;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 3 * (STEPS + 3);

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [RAW_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  tab_in_t          in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  tab_out_t         out_data;

  int               mismatch_count;
  int               tilt_pending;
  int               src_idle_pct  = 0;
  int               sink_idle_pct = 0;
  logic             hold_req      = 1'b0;
  int               hold_left     = 0;
  int               quiet_cycles  = 0;
  logic [RAW_W-1:0] cur_offset    = ADC_OFFSET_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tilt_angle_binning #(
    .ANGLE_FRAC_BITS(FRAC_BITS),
    .CORDIC_STEPS   (STEPS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  tab_checker #(
    .ANGLE_FRAC_BITS(FRAC_BITS),
    .CORDIC_STEPS   (STEPS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .tilt_pending  (tilt_pending)
  );

  // Result side: random back-pressure, or a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input tab_in_t s);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has been transferred.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (tilt_pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_offset(input logic [RAW_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_offset  = v;
  endtask

  // Biased toward the offset itself so that zero axes show up often.
  function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] ofs);
    case ($urandom_range(9))
      0:       return ofs;
      1:       return ofs + 8'd1;
      2:       return ofs - 8'd1;
      default: return RAW_W'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int               bin_z [9];
    logic [RAW_W-1:0] seg_offset;

    // z values that walk the xz angle through every 10-degree bin with x = +10.
    bin_z = '{82, 84, 86, 88, 91, 95, 102, 118, 195};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    src_idle_pct  = 37;
    sink_idle_pct = 88;

    // Reset offset: zero axes, zero denominators and both-zero angles.
    send_sample('{8'd81,  8'd81,  8'd81});
    send_sample('{8'd0,   8'd0,   8'd0});
    send_sample('{8'd255, 8'd255, 8'd255});
    send_sample('{8'd81,  8'd200, 8'd100});
    send_sample('{8'd81,  8'd0,   8'd0});
    send_sample('{8'd200, 8'd81,  8'd81});
    send_sample('{8'd0,   8'd255, 8'd81});
    send_sample('{8'd255, 8'd0,   8'd255});
    foreach (bin_z[i]) begin
      send_sample('{8'd91, 8'd150, RAW_W'(bin_z[i])});
    end
    drain();

    write_offset(8'd0);
    send_sample('{8'd0,   8'd0,   8'd0});
    send_sample('{8'd255, 8'd255, 8'd255});
    send_sample('{8'd255, 8'd0,   8'd128});
    drain();

    write_offset(8'd255);
    send_sample('{8'd255, 8'd255, 8'd255});
    send_sample('{8'd0,   8'd0,   8'd0});
    send_sample('{8'd0,   8'd255, 8'd128});
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        1:       seg_offset = 8'd0;
        2:       seg_offset = 8'd255;
        4:       seg_offset = ADC_OFFSET_RST;
        default: seg_offset = RAW_W'($urandom_range(255));
      endcase
      if (seg == 2) begin
        src_idle_pct  = 88;
        sink_idle_pct = 37;
      end
      if (seg == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // The sender keeps offering during this, so the block backs up.
        hold_req      = 1'b1;
      end
      write_offset(seg_offset);
      repeat (SEG_SAMPLES) begin
        send_sample('{pick_raw(cur_offset), pick_raw(cur_offset), pick_raw(cur_offset)});
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && tilt_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
